/* design/path_component_fnv_hasher_assert.svh */
// Assertion macros for the path component hasher.
`ifndef PATH_COMPONENT_FNV_HASHER_ASSERT_SVH
`define PATH_COMPONENT_FNV_HASHER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, off while reset is asserted.
`define PCFH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pcfh assertion failed");

// Clocked check that also holds during reset.
`define PCFH_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pcfh assertion failed");

`else

`define PCFH_ASSERT(lbl, clk, rst_n, prop)
`define PCFH_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* design/pcfh_pkg.sv */
// Shared types and constants for the path component hasher.
`timescale 1ns / 1ps

package pcfh_pkg;

	localparam int UNIT_W = 16;
	localparam int HASH_W = 32;
	localparam int ORD_W  = 16;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
	localparam logic [UNIT_W-1:0] SEP_BACK  = 16'h005C;
	localparam logic [UNIT_W-1:0] SEP_SLASH = 16'h002F;
	localparam logic [ORD_W-1:0]  ORD_MAX   = 16'hFFFF;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// work a queued unit asks of the hash engine
	typedef enum logic [1:0] {
		OP_FOLD,      // fold unit, component stays open
		OP_FOLD_EMIT, // fold unit, then close component (last unit)
		OP_EMIT,      // separator closes a pending component
		OP_EMPTY      // path ends with nothing pending
	} op_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		op_t               op;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [HASH_W-1:0] component_hash;
		logic [ORD_W-1:0]  component_ordinal;
		logic              present;
		logic              last_result;
	} result_t;

endpackage

/* design/pcfh_in_if.sv */
// Input channel: one code unit per transfer.
`timescale 1ns / 1ps

interface pcfh_in_if;
	logic                          valid;
	logic                          ready;
	logic [pcfh_pkg::UNIT_W-1:0]   code_unit;
	logic                          last_unit;

	modport source (output valid, output code_unit, output last_unit, input ready);
	modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

/* design/pcfh_out_if.sv */
// Output channel: one component result per transfer.
`timescale 1ns / 1ps

interface pcfh_out_if;
	logic                          valid;
	logic                          ready;
	logic [pcfh_pkg::HASH_W-1:0]   component_hash;
	logic [pcfh_pkg::ORD_W-1:0]    component_ordinal;
	logic                          present;
	logic                          last_result;

	modport source (output valid, output component_hash, output component_ordinal,
		output present, output last_result, input ready);
	modport sink (input valid, input component_hash, input component_ordinal,
		input present, input last_result, output ready);
endinterface

/* design/path_component_fnv_hasher.sv */
// Top level of the path component hasher: front, command queue, hash back end.
// A plain code unit passes through TAKE (low byte round) and HIGH (high byte round), one FNV
// round per byte; a unit ending a component then waits in EMIT for the output register, and its
// result is loaded there from EMIT. A closing separator is emitted directly from TAKE.
// A new code unit is taken only once the last has finished its rounds on the shared FNV multiplier.
// Reset (arst_n low, asynchronous): queue empty, hash at offset basis, ordinal zero.
`timescale 1ns / 1ps

module path_component_fnv_hasher #(
	parameter int QUEUE_DEPTH = pcfh_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	pcfh_in_if.sink      in_ch,
	pcfh_out_if.source   out_ch
);

	// front -> queue
	logic             push;
	pcfh_pkg::cmd_t   push_cmd;
	logic             q_full;

	// queue -> back
	logic             q_valid;
	logic             pop;
	pcfh_pkg::cmd_t   head;

	// Front: accepts a transfer whenever the queue has room, tags each unit with
	// the work it needs and swallows separators that close nothing, unless they end the path.
	pcfh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// Queue decouples input stalls from the two-round hash engine.
	pcfh_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.q_valid  (q_valid),
		.head     (head)
	);

	// Back: folds low then high byte, closes components, counts ordinals
	// (saturating) and holds each result in an output register until taken.
	pcfh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

/* design/pcfh_front.sv */
// Front end: classifies code units and drops separators with nothing pending, unless they end the path.
`timescale 1ns / 1ps
`include "path_component_fnv_hasher_assert.svh"

module pcfh_front (
	input  logic             clk,
	input  logic             arst_n,
	pcfh_in_if.sink          in_ch,
	input  logic             q_full,
	output logic             push,
	output pcfh_pkg::cmd_t   cmd
);

	logic pending_q;
	logic accept;
	logic is_sep;
	logic keep;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_sep      = (in_ch.code_unit == pcfh_pkg::SEP_BACK) ||
		(in_ch.code_unit == pcfh_pkg::SEP_SLASH);
	// a bare separator mid-path changes nothing downstream
	assign keep        = !is_sep || pending_q || in_ch.last_unit;
	assign push        = accept && keep;

	always_comb begin
		cmd.unit = in_ch.code_unit;
		cmd.last = in_ch.last_unit;
		if (!is_sep) begin
			cmd.op = in_ch.last_unit ? pcfh_pkg::OP_FOLD_EMIT : pcfh_pkg::OP_FOLD;
		end else if (pending_q) begin
			cmd.op = pcfh_pkg::OP_EMIT;
		end else begin
			cmd.op = pcfh_pkg::OP_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= !is_sep && !in_ch.last_unit;
		end
	end

	`PCFH_ASSERT(a_last_ends_path, clk, arst_n, accept && in_ch.last_unit |=> !pending_q)

endmodule

/* design/pcfh_fifo.sv */
// Short command queue between front and back.
`timescale 1ns / 1ps
`include "path_component_fnv_hasher_assert.svh"

module pcfh_fifo #(
	parameter int DEPTH = pcfh_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcfh_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output logic             full,
	output logic             q_valid,
	output pcfh_pkg::cmd_t   head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcfh_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	`PCFH_ASSERT(a_no_overflow, clk, arst_n, push |-> (count_q < CNT_W'(DEPTH)) || pop)
	`PCFH_ASSERT(a_no_underflow, clk, arst_n, pop |-> q_valid)

endmodule

/* design/pcfh_back.sv */
// Back end: FNV-1a engine, ordinal counter and output register.
`timescale 1ns / 1ps
`include "path_component_fnv_hasher_assert.svh"

module pcfh_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  pcfh_pkg::cmd_t   head,
	output logic             pop,
	pcfh_out_if.source       out_ch
);

	typedef enum logic [1:0] {
		ST_TAKE, // low byte round, or direct emit
		ST_HIGH, // high byte round
		ST_EMIT  // wait for output slot to close component
	} state_t;

	state_t                         state_q;
	pcfh_pkg::cmd_t                 cmd_q;
	logic [pcfh_pkg::HASH_W-1:0]    hash_q;
	logic [pcfh_pkg::ORD_W-1:0]     ord_q;
	logic                           out_valid_q;
	pcfh_pkg::result_t              res_q;

	logic [7:0]                     mul_byte;
	logic [pcfh_pkg::HASH_W-1:0]    mul_res;
	logic [pcfh_pkg::ORD_W-1:0]     ord_inc;
	logic                           out_free;
	logic                           do_emit;
	logic                           head_folds;
	pcfh_pkg::cmd_t                 emit_cmd;

	assign head_folds = (head.op == pcfh_pkg::OP_FOLD) || (head.op == pcfh_pkg::OP_FOLD_EMIT);
	assign out_free   = !out_valid_q || out_ch.ready;
	assign ord_inc    = (ord_q == pcfh_pkg::ORD_MAX) ? ord_q : ord_q + pcfh_pkg::ORD_W'(1);

	// single shared multiplier: low byte in TAKE, high byte in HIGH
	assign mul_byte = (state_q == ST_TAKE) ? head.unit[7:0] : cmd_q.unit[15:8];
	assign mul_res  = pcfh_pkg::HASH_W'((hash_q ^ {24'd0, mul_byte}) * pcfh_pkg::FNV_PRIME);

	always_comb begin
		pop      = 1'b0;
		do_emit  = 1'b0;
		emit_cmd = cmd_q;
		unique case (state_q)
			ST_TAKE: begin
				if (q_valid) begin
					if (head_folds) begin
						pop = 1'b1;
					end else if (out_free) begin
						pop      = 1'b1;
						do_emit  = 1'b1;
						emit_cmd = head;
					end
				end
			end
			ST_HIGH: begin
			end
			ST_EMIT: begin
				do_emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			cmd_q       <= '0;
			hash_q      <= pcfh_pkg::FNV_BASIS;
			ord_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_TAKE: begin
					if (pop) begin
						cmd_q <= head;
						if (head_folds) begin
							hash_q  <= mul_res;
							state_q <= ST_HIGH;
						end
					end
				end
				ST_HIGH: begin
					hash_q  <= mul_res;
					state_q <= (cmd_q.op == pcfh_pkg::OP_FOLD_EMIT) ? ST_EMIT : ST_TAKE;
				end
				ST_EMIT: begin
					if (do_emit) begin
						state_q <= ST_TAKE;
					end
				end
				default: begin
					state_q <= ST_TAKE;
				end
			endcase
			if (do_emit) begin
				out_valid_q       <= 1'b1;
				res_q.last_result <= emit_cmd.last;
				if (emit_cmd.op == pcfh_pkg::OP_EMPTY) begin
					res_q.component_hash    <= '0;
					res_q.component_ordinal <= '0;
					res_q.present           <= 1'b0;
					ord_q                   <= '0;
				end else begin
					res_q.component_hash    <= hash_q;
					res_q.component_ordinal <= ord_inc;
					res_q.present           <= 1'b1;
					ord_q                   <= emit_cmd.last ? '0 : ord_inc;
				end
				hash_q <= pcfh_pkg::FNV_BASIS;
			end
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.component_hash    = res_q.component_hash;
	assign out_ch.component_ordinal = res_q.component_ordinal;
	assign out_ch.present           = res_q.present;
	assign out_ch.last_result       = res_q.last_result;

	`PCFH_ASSERT(a_last_resets_path, clk, arst_n, do_emit && emit_cmd.last |=> (ord_q == '0) && (hash_q == pcfh_pkg::FNV_BASIS))
	`PCFH_ASSERT(a_empty_is_last, clk, arst_n, !(out_valid_q && !res_q.present) || res_q.last_result)

endmodule
